>>> rtl/lmssi_pkg.sv
// ----------------------------------------------------------------------------
// lmssi_pkg
// Shared types and constants for the four-tap LMS system identification block.
// ----------------------------------------------------------------------------
package lmssi_pkg;

  localparam int TAPS       = 4;
  localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int NUM_COEF   = 4;
  localparam int COEF_IW    = $clog2(NUM_COEF);
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0]  REG_STEP_SIZE = CFG_IDX_W'(NUM_COEF);
  localparam logic [CFG_DATA_W-1:0] STEP_RESET    = 16'sd1000;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAC  = 7'b0000010,
    S_ERR  = 7'b0000100,
    S_MU   = 7'b0001000,
    S_MUW  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_ADD  = 2'd1,
    K_SUB  = 2'd2,
    K_WUPD = 2'd3
  } prod_kind_t;

endpackage

>>> rtl/lms_system_identification.sv
// ----------------------------------------------------------------------------
// lms_system_identification
// Four-tap fixed-point LMS system identification on one shared 16x16 multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | payload
//  ---------+-----+----------------------------------+------------------------
//  in       | in  | in_tvalid, in_tready, in_tdata   | in_sample  [15:0]
//  out      | out | out_tvalid, out_tready, out_tdata| error_out  [15:0]
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata     | 0..3 plant coefs, 4 step
//
//  A new sample is taken only in idle, after the previous one has gone through
//  every state; the block does not work on two samples at once.
//  Every multiply goes through the single registered multiplier: 2*TAPS
//  filter products, one step product, TAPS weight updates.
//  rst_n is synchronous, active low: weights, delay line and coefficients
//  clear, step size returns to 1000.
//  A new sample is taken while a result waits; the final step holds until the
//  output register is free.
// ----------------------------------------------------------------------------
module lms_system_identification (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [15:0]                          in_tdata,   // [15:0] in_sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,  // [15:0] error_out
  input  logic                                 cfg_we,
  input  logic [lmssi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmssi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TAPS = lmssi_pkg::TAPS;
  localparam int TW   = lmssi_pkg::TAP_W;
  localparam int SW   = lmssi_pkg::SAMPLE_W;
  localparam int WW   = lmssi_pkg::WEIGHT_W;

  lmssi_pkg::state_t     state_r, state_nxt;
  logic [TW-1:0]         tidx_r, tidx_nxt;
  logic                  est_r, est_nxt;

  logic [SW-1:0]         coef_r [lmssi_pkg::NUM_COEF];
  logic [SW-1:0]         step_r;
  logic [SW-1:0]         taps_r [TAPS];
  logic [WW-1:0]         weights_r [TAPS];

  logic signed [SW-1:0]  mul_a, mul_b;
  logic signed [WW-1:0]  prod_r;
  logic                  issue;
  lmssi_pkg::prod_kind_t kind_nxt, kind_r;
  logic [TW-1:0]         pidx_r;

  logic [WW-1:0]         acc_r;
  logic [SW-1:0]         err_r;
  logic [SW-1:0]         mu_r;

  logic                  out_tvalid_r;
  logic [SW-1:0]         out_tdata_r;
  logic                  out_free;
  logic                  tidx_last;

  assign in_tready  = (state_r == lmssi_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign tidx_last  = (tidx_r == TW'(TAPS - 1));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    tidx_nxt  = tidx_r;
    est_nxt   = est_r;
    case (state_r)
      lmssi_pkg::S_IDLE: begin
        tidx_nxt = '0;
        est_nxt  = 1'b0;
        if (in_tvalid) begin
          state_nxt = lmssi_pkg::S_MAC;
        end
      end
      lmssi_pkg::S_MAC: begin
        if (tidx_last) begin
          tidx_nxt = '0;
          est_nxt  = 1'b1;
          if (est_r) begin
            state_nxt = lmssi_pkg::S_ERR;
          end
        end else begin
          tidx_nxt = tidx_r + 1'b1;
        end
      end
      lmssi_pkg::S_ERR: state_nxt = lmssi_pkg::S_MU;
      lmssi_pkg::S_MU:  state_nxt = lmssi_pkg::S_MUW;
      lmssi_pkg::S_MUW: state_nxt = lmssi_pkg::S_UPD;
      lmssi_pkg::S_UPD: begin
        if (tidx_last) begin
          state_nxt = lmssi_pkg::S_FIN;
        end else begin
          tidx_nxt = tidx_r + 1'b1;
        end
      end
      lmssi_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = lmssi_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmssi_pkg::S_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    issue    = 1'b0;
    kind_nxt = lmssi_pkg::K_NONE;
    case (state_r)
      lmssi_pkg::S_MAC: begin
        issue = 1'b1;
        mul_a = $signed(taps_r[tidx_r]);
        if (est_r) begin
          mul_b    = $signed(weights_r[tidx_r][WW-1 -: SW]);
          kind_nxt = lmssi_pkg::K_SUB;
        end else begin
          mul_b    = $signed(coef_r[lmssi_pkg::COEF_IW'(tidx_r)]);
          kind_nxt = lmssi_pkg::K_ADD;
        end
      end
      lmssi_pkg::S_MU: begin
        issue = 1'b1;
        mul_a = $signed(step_r);
        mul_b = $signed(acc_r[WW-1 -: SW]);
      end
      lmssi_pkg::S_UPD: begin
        issue    = 1'b1;
        mul_a    = $signed(mu_r);
        mul_b    = $signed(taps_r[tidx_r]);
        kind_nxt = lmssi_pkg::K_WUPD;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    pidx_r <= tidx_r;
    if (!rst_n) begin
      state_r <= lmssi_pkg::S_IDLE;
      tidx_r  <= '0;
      est_r   <= 1'b0;
      kind_r  <= lmssi_pkg::K_NONE;
    end else begin
      state_r <= state_nxt;
      tidx_r  <= tidx_nxt;
      est_r   <= est_nxt;
      kind_r  <= issue ? kind_nxt : lmssi_pkg::K_NONE;
    end
  end

  // accumulator, error and scaled error
  always_ff @(posedge clk) begin
    if (state_r == lmssi_pkg::S_IDLE) begin
      acc_r <= '0;
    end else if (kind_r == lmssi_pkg::K_ADD) begin
      acc_r <= acc_r + $unsigned(prod_r);
    end else if (kind_r == lmssi_pkg::K_SUB) begin
      acc_r <= acc_r - $unsigned(prod_r);
    end
    if (state_r == lmssi_pkg::S_MU) begin
      err_r <= acc_r[WW-1 -: SW];
    end
    if (state_r == lmssi_pkg::S_MUW) begin
      mu_r <= prod_r[WW-1 -: SW];
    end
  end

  // configuration, weights and delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < lmssi_pkg::NUM_COEF; n++) begin
        coef_r[n] <= '0;
      end
      for (int n = 0; n < TAPS; n++) begin
        taps_r[n]    <= '0;
        weights_r[n] <= '0;
      end
      step_r <= lmssi_pkg::STEP_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index < lmssi_pkg::REG_STEP_SIZE) begin
          coef_r[lmssi_pkg::COEF_IW'(cfg_index)] <= cfg_wdata;
        end else if (cfg_index == lmssi_pkg::REG_STEP_SIZE) begin
          step_r <= cfg_wdata;
        end
      end
      if (kind_r == lmssi_pkg::K_WUPD) begin
        weights_r[pidx_r] <= weights_r[pidx_r] + $unsigned(prod_r);
      end
      if (in_tvalid && in_tready) begin
        taps_r[0] <= in_tdata;
      end else if (state_r == lmssi_pkg::S_FIN && out_free) begin
        for (int n = 1; n < TAPS; n++) begin
          taps_r[n] <= taps_r[n-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == lmssi_pkg::S_FIN && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (state_r == lmssi_pkg::S_FIN && out_free) begin
      out_tdata_r <= err_r;
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-tap LMS system identification block.
// Samples go in over the input stream, each one is run through a bit-exact
// model of the plant, the adaptive filter and the weight update, and every
// error word on the output stream is compared with the oldest prediction.
// Plant coefficients and step size change between phases while the block is
// idle. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lmssi_pkg::CFG_IDX_W-1:0] REG_PLANT_COEF_0 = '0;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_TRACK, MIX_NEG_STEP} coef_mix_t;

  // Bit-exact predictor of the error stream plus the queue of pending results.
  class lms_error_tracker;
    logic signed [15:0] plant_coef [lmssi_pkg::NUM_COEF];
    logic signed [15:0] step_gain;
    logic signed [15:0] delay_line [lmssi_pkg::TAPS];
    logic signed [31:0] weight [lmssi_pkg::TAPS];
    logic [15:0]        pending_errors [$];
    int                 mismatches;

    function new();
      foreach (plant_coef[n]) plant_coef[n] = '0;
      foreach (delay_line[n]) delay_line[n] = '0;
      foreach (weight[n]) weight[n] = '0;
      step_gain  = lmssi_pkg::STEP_RESET;
      mismatches = 0;
    endfunction

    function void write_register(logic [lmssi_pkg::CFG_IDX_W-1:0] index,
                                 logic [15:0] value);
      if (index < lmssi_pkg::NUM_COEF) begin
        plant_coef[index] = value;
      end else if (index == lmssi_pkg::REG_STEP_SIZE) begin
        step_gain = value;
      end
    endfunction

    function void note_sample(logic [15:0] sample);
      logic signed [15:0] tap [lmssi_pkg::TAPS];
      logic signed [31:0] desired, estimate, err, scaled;
      logic signed [15:0] err_hi, mu_err, w_hi;
      tap[0] = sample;
      for (int n = 1; n < lmssi_pkg::TAPS; n++) tap[n] = delay_line[n-1];
      desired  = '0;
      estimate = '0;
      for (int n = 0; n < lmssi_pkg::TAPS; n++) begin
        w_hi     = weight[n][31:16];
        desired  = desired + plant_coef[n] * tap[n];
        estimate = estimate + tap[n] * w_hi;
      end
      err    = desired - estimate;
      err_hi = err[31:16];
      scaled = step_gain * err_hi;
      mu_err = scaled[31:16];
      for (int n = 0; n < lmssi_pkg::TAPS; n++) weight[n] = weight[n] + mu_err * tap[n];
      for (int n = 0; n + 1 < lmssi_pkg::TAPS; n++) delay_line[n] = tap[n];
      pending_errors.push_back(err_hi);
    endfunction

    function void check_error(logic [15:0] actual);
      logic [15:0] predicted;
      if (pending_errors.size() == 0) begin
        mismatches++;
        $display("%0t: error_out expected none actual %0d", $time, $signed(actual));
      end else begin
        predicted = pending_errors.pop_front();
        if (predicted !== actual) begin
          mismatches++;
          $display("%0t: error_out expected %0d actual %0d", $time,
                   $signed(predicted), $signed(actual));
        end
      end
    endfunction

    function int pending();
      return pending_errors.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [15:0]                      in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [15:0]                      out_tdata;
  logic                             cfg_we;
  logic [lmssi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lmssi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lms_error_tracker tracker;
  bit               steady;
  int               results_seen;
  int               cycle_count;

  lms_system_identification dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [15:0] random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom);
    if (r < 85) return 16'($signed($urandom_range(0, 2047)) - 1024);
    return extreme_value();
  endfunction

  task automatic write_reg(logic [lmssi_pkg::CFG_IDX_W-1:0] index, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_register(index, value);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] c3, logic [15:0] step);
    write_reg(REG_PLANT_COEF_0, c0);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 1), c1);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 2), c2);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 3), c3);
    write_reg(lmssi_pkg::REG_STEP_SIZE, step);
    // index past the register list, must be ignored
    write_reg(lmssi_pkg::CFG_IDX_W'(lmssi_pkg::REG_STEP_SIZE + 1 + $urandom_range(0, 2)),
              16'($urandom));
    end_writes();
  endtask

  task automatic send_sample(logic [15:0] sample);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_sample(sample);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // result side: random stall stretches, one long hold-off once traffic is going
  initial begin : receiver
    int  hold;
    int  burst;
    bit  long_hold_done;
    out_tready     <= 1'b0;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_hold_done && results_seen >= 500) begin
        hold           = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        @(posedge clk);
        if (out_tvalid) begin
          tracker.check_error(out_tdata);
          results_seen++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] seq [$];
    logic [15:0] c [4];
    logic [15:0] step;
    coef_mix_t   mix;
    tracker      = new();
    steady       = 1'b0;
    results_seen = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step size left at its reset value here
    write_reg(REG_PLANT_COEF_0, 16'h7FFF);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 1), 16'h8000);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 2), 16'd12345);
    write_reg(lmssi_pkg::CFG_IDX_W'(REG_PLANT_COEF_0 + 3), 16'hFFFF);
    end_writes();
    seq = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'h5555, 16'hAAAA,
            16'h7FFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain();

    set_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    seq = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain();

    set_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    seq = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain();

    set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
    seq = '{16'h1234, 16'h8000, 16'h7FFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      mix = coef_mix_t'(phase % 4);
      case (mix)
        MIX_FULL: begin
          foreach (c[k]) c[k] = 16'($urandom);
          step = 16'($urandom);
        end
        MIX_EXTREME: begin
          foreach (c[k]) c[k] = extreme_value();
          step = extreme_value();
        end
        MIX_TRACK: begin
          foreach (c[k]) c[k] = 16'($signed($urandom_range(0, 16000)) - 8000);
          step = 16'($urandom_range(1, 4000));
        end
        default: begin
          foreach (c[k]) c[k] = 16'($urandom);
          step = 16'($signed($urandom_range(1, 32768)) * -1);
        end
      endcase
      set_config(c[0], c[1], c[2], c[3], step);
      steady = (phase == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 2 && i == PHASE_ITEMS / 2) drain();
        send_sample(random_sample());
      end
      drain();
      steady = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
